// ===== src/segment_intersect_depth_assert.svh =====
// assertion helpers for the segment intersection block
`ifndef SEGMENT_INTERSECT_DEPTH_ASSERT_SVH
`define SEGMENT_INTERSECT_DEPTH_ASSERT_SVH

// checked on every edge, reset masked
`define SID_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SID_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sid_pkg.sv =====
`default_nettype none
package sid_pkg;
	localparam int MID_DEPTH = 8;
	localparam int PTR_W     = 3;
	localparam int CNT_W     = 4;
	localparam int FLIGHT_W  = 3;

	localparam int DET_THR_W = 33;
	localparam int EXT_THR_W = 17;
	localparam int CFG_DATA_W = 33;

	localparam logic REG_DET_THR = 1'b0;
	localparam logic REG_EXT_THR = 1'b1;

	localparam logic [DET_THR_W-1:0] DET_THR_RST = 33'd4295;
	localparam logic [EXT_THR_W-1:0] EXT_THR_RST = 17'd1;

	typedef struct packed {
		logic             empty;
		logic [CNT_W-1:0] count;
	} sid_qstat_t;
endpackage
`default_nettype wire

// ===== src/sid_queue.sv =====
`default_nettype none
module sid_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire logic [WIDTH-1:0]   wdata,
	input  wire logic               pop,
	output logic [WIDTH-1:0]        rdata,
	output sid_pkg::sid_qstat_t     stat
);
	import sid_pkg::*;

	logic [WIDTH-1:0] mem_q [MID_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			case ({push, pop})
				2'b10: count_q <= count_q + CNT_W'(1);
				2'b01: count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign rdata      = mem_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;
endmodule
`default_nettype wire

// ===== src/sid_front.sv =====
`default_nettype none
module sid_front #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16,
	parameter int ITEM_W      = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic signed [COORD_WIDTH-1:0] a_x,
	input  wire logic signed [COORD_WIDTH-1:0] a_y,
	input  wire logic signed [COORD_WIDTH-1:0] a_z,
	input  wire logic signed [COORD_WIDTH-1:0] b_x,
	input  wire logic signed [COORD_WIDTH-1:0] b_y,
	input  wire logic signed [COORD_WIDTH-1:0] b_z,
	input  wire logic signed [COORD_WIDTH-1:0] c_x,
	input  wire logic signed [COORD_WIDTH-1:0] c_y,
	input  wire logic signed [COORD_WIDTH-1:0] c_z,
	input  wire logic signed [COORD_WIDTH-1:0] d_x,
	input  wire logic signed [COORD_WIDTH-1:0] d_y,
	input  wire logic signed [COORD_WIDTH-1:0] d_z,
	input  wire logic [sid_pkg::DET_THR_W-1:0] det_thr,
	input  wire logic [sid_pkg::EXT_THR_W-1:0] ext_thr,
	output logic                               out_valid,
	output logic [ITEM_W-1:0]                  out_data,
	output logic [sid_pkg::FLIGHT_W-1:0]       inflight
);
	import sid_pkg::*;

	localparam int C   = COORD_WIDTH;
	localparam int C1  = C + 1;
	localparam int PW  = 2 * C + 2;
	localparam int M   = 2 * C + 3;
	localparam int TW  = M + 32 + 2 * FRAC_BITS + DET_THR_W;
	localparam int DEG_L = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	localparam int DEG_R = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int DW  = C1 + EXT_THR_W + 16 + 8;

	// stage 1: differences
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [C1-1:0] rx_s1, ry_s1, sx_s1, sy_s1, ex_s1, ey_s1, dzab_s1, dzcd_s1;
	logic signed [C-1:0]  az_s1, cz_s1;

	always_ff @(posedge clk) begin
		rx_s1   <= C1'(b_x) - C1'(a_x);
		ry_s1   <= C1'(b_y) - C1'(a_y);
		sx_s1   <= C1'(d_x) - C1'(c_x);
		sy_s1   <= C1'(d_y) - C1'(c_y);
		ex_s1   <= C1'(c_x) - C1'(a_x);
		ey_s1   <= C1'(c_y) - C1'(a_y);
		dzab_s1 <= C1'(b_z) - C1'(a_z);
		dzcd_s1 <= C1'(d_z) - C1'(c_z);
		az_s1   <= a_z;
		cz_s1   <= c_z;
	end

	// stage 2: products, extents
	logic [C1-1:0] arx, ary, asx, asy, e_ab, e_cd;
	logic signed [PW-1:0] p_rs_s2, p_ss_s2, p_es1_s2, p_es2_s2, p_er1_s2, p_er2_s2;
	logic deg_ab_s2, deg_cd_s2, dzab_neg_s2, dzcd_neg_s2;
	logic [C1-1:0] dzab_mag_s2, dzcd_mag_s2;
	logic signed [C-1:0] az_s2, cz_s2;

	always_comb begin
		arx  = rx_s1[C1-1] ? C1'(-rx_s1) : C1'(rx_s1);
		ary  = ry_s1[C1-1] ? C1'(-ry_s1) : C1'(ry_s1);
		asx  = sx_s1[C1-1] ? C1'(-sx_s1) : C1'(sx_s1);
		asy  = sy_s1[C1-1] ? C1'(-sy_s1) : C1'(sy_s1);
		e_ab = (arx > ary) ? arx : ary;
		e_cd = (asx > asy) ? asx : asy;
	end

	always_ff @(posedge clk) begin
		p_rs_s2  <= rx_s1 * sy_s1;
		p_ss_s2  <= ry_s1 * sx_s1;
		p_es1_s2 <= ex_s1 * sy_s1;
		p_es2_s2 <= ey_s1 * sx_s1;
		p_er1_s2 <= ex_s1 * ry_s1;
		p_er2_s2 <= ey_s1 * rx_s1;
		deg_ab_s2 <= (DW'(e_ab) << DEG_L) < (DW'(ext_thr) << DEG_R);
		deg_cd_s2 <= (DW'(e_cd) << DEG_L) < (DW'(ext_thr) << DEG_R);
		dzab_neg_s2 <= dzab_s1[C1-1];
		dzcd_neg_s2 <= dzcd_s1[C1-1];
		dzab_mag_s2 <= dzab_s1[C1-1] ? C1'(-dzab_s1) : C1'(dzab_s1);
		dzcd_mag_s2 <= dzcd_s1[C1-1] ? C1'(-dzcd_s1) : C1'(dzcd_s1);
		az_s2 <= az_s1;
		cz_s2 <= cz_s1;
	end

	// stage 3: cross products
	logic signed [M-1:0] det_s3, tn_s3, un_s3;
	logic deg_ab_s3, deg_cd_s3, dzab_neg_s3, dzcd_neg_s3;
	logic [C1-1:0] dzab_mag_s3, dzcd_mag_s3;
	logic signed [C-1:0] az_s3, cz_s3;

	always_ff @(posedge clk) begin
		det_s3 <= M'(p_rs_s2) - M'(p_ss_s2);
		tn_s3  <= M'(p_es1_s2) - M'(p_es2_s2);
		un_s3  <= M'(p_er1_s2) - M'(p_er2_s2);
		deg_ab_s3 <= deg_ab_s2;
		deg_cd_s3 <= deg_cd_s2;
		dzab_neg_s3 <= dzab_neg_s2;
		dzcd_neg_s3 <= dzcd_neg_s2;
		dzab_mag_s3 <= dzab_mag_s2;
		dzcd_mag_s3 <= dzcd_mag_s2;
		az_s3 <= az_s2;
		cz_s3 <= cz_s2;
	end

	// stage 4: magnitudes
	logic [M-1:0] det_mag_s4, tn_mag_s4, un_mag_s4;
	logic det_neg_s4, tn_neg_s4, un_neg_s4;
	logic deg_ab_s4, deg_cd_s4, dzab_neg_s4, dzcd_neg_s4;
	logic [C1-1:0] dzab_mag_s4, dzcd_mag_s4;
	logic signed [C-1:0] az_s4, cz_s4;

	always_ff @(posedge clk) begin
		det_mag_s4 <= det_s3[M-1] ? M'(-det_s3) : M'(det_s3);
		tn_mag_s4  <= tn_s3[M-1] ? M'(-tn_s3) : M'(tn_s3);
		un_mag_s4  <= un_s3[M-1] ? M'(-un_s3) : M'(un_s3);
		det_neg_s4 <= det_s3[M-1];
		tn_neg_s4  <= tn_s3[M-1];
		un_neg_s4  <= un_s3[M-1];
		deg_ab_s4 <= deg_ab_s3;
		deg_cd_s4 <= deg_cd_s3;
		dzab_neg_s4 <= dzab_neg_s3;
		dzcd_neg_s4 <= dzcd_neg_s3;
		dzab_mag_s4 <= dzab_mag_s3;
		dzcd_mag_s4 <= dzcd_mag_s3;
		az_s4 <= az_s3;
		cz_s4 <= cz_s3;
	end

	// stage 5: classify
	logic det_zero, thr_low, t_in, u_in;
	logic hit_s5, deg_ab_s5, deg_cd_s5, neg_ab_s5, neg_cd_s5;
	logic [M-1:0] det_mag_s5, tn_mag_s5, un_mag_s5;
	logic [C1-1:0] dzab_mag_s5, dzcd_mag_s5;
	logic signed [C-1:0] az_s5, cz_s5;

	always_comb begin
		det_zero = (det_mag_s4 == '0);
		thr_low  = (TW'(det_mag_s4) << 32) < (TW'(det_thr) << (2 * FRAC_BITS));
		t_in = (tn_mag_s4 == '0) || ((tn_neg_s4 == det_neg_s4) && (tn_mag_s4 <= det_mag_s4));
		u_in = (un_mag_s4 == '0) || ((un_neg_s4 == det_neg_s4) && (un_mag_s4 <= det_mag_s4));
	end

	always_ff @(posedge clk) begin
		hit_s5 <= !det_zero && !thr_low && t_in && u_in;
		deg_ab_s5 <= deg_ab_s4;
		deg_cd_s5 <= deg_cd_s4;
		neg_ab_s5 <= tn_neg_s4 ^ dzab_neg_s4 ^ det_neg_s4;
		neg_cd_s5 <= un_neg_s4 ^ dzcd_neg_s4 ^ det_neg_s4;
		det_mag_s5 <= det_mag_s4;
		tn_mag_s5  <= tn_mag_s4;
		un_mag_s5  <= un_mag_s4;
		dzab_mag_s5 <= dzab_mag_s4;
		dzcd_mag_s5 <= dzcd_mag_s4;
		az_s5 <= az_s4;
		cz_s5 <= cz_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_data  = {hit_s5, deg_ab_s5, deg_cd_s5, neg_ab_s5, neg_cd_s5,
		det_mag_s5, tn_mag_s5, un_mag_s5, az_s5, dzab_mag_s5, cz_s5, dzcd_mag_s5};
	assign inflight  = FLIGHT_W'($countones({v_s1, v_s2, v_s3, v_s4, v_s5}));
endmodule
`default_nettype wire

// ===== src/sid_back.sv =====
`default_nettype none
module sid_back #(
	parameter int COORD_WIDTH = 32,
	parameter int ITEM_W      = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire logic [ITEM_W-1:0]      in_data,
	input  wire logic                   pop,
	output logic                        take,
	output logic                        out_valid,
	output logic                        hit,
	output logic signed [COORD_WIDTH-1:0] depth_ab,
	output logic signed [COORD_WIDTH-1:0] depth_cd
);
	localparam int C   = COORD_WIDTH;
	localparam int C1  = C + 1;
	localparam int C2  = C + 2;
	localparam int M   = 2 * C + 3;
	localparam int H   = (M + 1) / 2;
	localparam int PW  = M + C1;
	localparam int QB  = C1;

	typedef struct packed {
		logic                hit;
		logic                deg_ab;
		logic                deg_cd;
		logic                neg_ab;
		logic                neg_cd;
		logic [M-1:0]        den;
		logic [PW-1:0]       rem_ab;
		logic [PW-1:0]       rem_cd;
		logic [QB-1:0]       q_ab;
		logic [QB-1:0]       q_cd;
		logic signed [C-1:0] z_ab;
		logic signed [C-1:0] z_cd;
	} dstage_t;

	logic en;
	logic u_hit, u_deg_ab, u_deg_cd, u_neg_ab, u_neg_cd;
	logic [M-1:0] u_det, u_tn, u_un;
	logic signed [C-1:0] u_az, u_cz;
	logic [C1-1:0] u_dzab, u_dzcd;

	assign {u_hit, u_deg_ab, u_deg_cd, u_neg_ab, u_neg_cd,
		u_det, u_tn, u_un, u_az, u_dzab, u_cz, u_dzcd} = in_data;

	assign en   = !out_valid || pop;
	assign take = en && in_valid;

	// stage 1: partial products
	logic v_s1, v_s2;
	logic [H+C1-1:0]     lo_ab_s1, lo_cd_s1;
	logic [M-H+C1-1:0]   hi_ab_s1, hi_cd_s1;
	logic hit_s1, deg_ab_s1, deg_cd_s1, neg_ab_s1, neg_cd_s1;
	logic [M-1:0] den_s1;
	logic signed [C-1:0] az_s1, cz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			lo_ab_s1 <= u_tn[H-1:0] * u_dzab;
			hi_ab_s1 <= u_tn[M-1:H] * u_dzab;
			lo_cd_s1 <= u_un[H-1:0] * u_dzcd;
			hi_cd_s1 <= u_un[M-1:H] * u_dzcd;
			hit_s1 <= u_hit;
			deg_ab_s1 <= u_deg_ab;
			deg_cd_s1 <= u_deg_cd;
			neg_ab_s1 <= u_neg_ab;
			neg_cd_s1 <= u_neg_cd;
			den_s1 <= u_det;
			az_s1 <= u_az;
			cz_s1 <= u_cz;
		end
	end

	// stage 2: product sum, divider entry
	dstage_t st_q [QB+1];
	logic    vd_q [QB+1];

	always_ff @(posedge clk) begin
		if (en) begin
			st_q[0].hit    <= hit_s1;
			st_q[0].deg_ab <= deg_ab_s1;
			st_q[0].deg_cd <= deg_cd_s1;
			st_q[0].neg_ab <= neg_ab_s1;
			st_q[0].neg_cd <= neg_cd_s1;
			st_q[0].den    <= den_s1;
			st_q[0].rem_ab <= PW'(lo_ab_s1) + (PW'(hi_ab_s1) << H);
			st_q[0].rem_cd <= PW'(lo_cd_s1) + (PW'(hi_cd_s1) << H);
			st_q[0].q_ab   <= '0;
			st_q[0].q_cd   <= '0;
			st_q[0].z_ab   <= az_s1;
			st_q[0].z_cd   <= cz_s1;
		end
	end

	// one quotient bit per stage, msb first
	for (genvar k = 0; k < QB; k++) begin : g_div
		localparam int I = QB - 1 - k;
		logic [PW-1:0] dsh;
		logic ge_ab, ge_cd;
		dstage_t nxt;

		always_comb begin
			dsh   = PW'(st_q[k].den) << I;
			ge_ab = st_q[k].rem_ab >= dsh;
			ge_cd = st_q[k].rem_cd >= dsh;
			nxt   = st_q[k];
			if (ge_ab) nxt.rem_ab = st_q[k].rem_ab - dsh;
			if (ge_cd) nxt.rem_cd = st_q[k].rem_cd - dsh;
			nxt.q_ab[I] = ge_ab;
			nxt.q_cd[I] = ge_cd;
		end

		always_ff @(posedge clk) begin
			if (en) st_q[k+1] <= nxt;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vd_q[k+1] <= 1'b0;
			else if (en) vd_q[k+1] <= vd_q[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else if (en) begin
			v_s1    <= in_valid;
			v_s2    <= v_s1;
		end
	end

	assign vd_q[0] = v_s2;

	// final add and saturation
	logic signed [C2-1:0] v_ab, v_cd;
	logic signed [C-1:0]  s_ab, s_cd;
	localparam logic signed [C-1:0] ZMAX = {1'b0, {(C-1){1'b1}}};
	localparam logic signed [C-1:0] ZMIN = {1'b1, {(C-1){1'b0}}};

	always_comb begin
		v_ab = st_q[QB].neg_ab ? C2'(st_q[QB].z_ab) - C2'(st_q[QB].q_ab)
			: C2'(st_q[QB].z_ab) + C2'(st_q[QB].q_ab);
		v_cd = st_q[QB].neg_cd ? C2'(st_q[QB].z_cd) - C2'(st_q[QB].q_cd)
			: C2'(st_q[QB].z_cd) + C2'(st_q[QB].q_cd);
		if (v_ab[C2-1:C-1] == '0 || v_ab[C2-1:C-1] == '1) s_ab = v_ab[C-1:0];
		else s_ab = v_ab[C2-1] ? ZMIN : ZMAX;
		if (v_cd[C2-1:C-1] == '0 || v_cd[C2-1:C-1] == '1) s_cd = v_cd[C-1:0];
		else s_cd = v_cd[C2-1] ? ZMIN : ZMAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= vd_q[QB];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit      <= st_q[QB].hit;
			depth_ab <= (st_q[QB].hit && !st_q[QB].deg_ab) ? s_ab : '0;
			depth_cd <= (st_q[QB].hit && !st_q[QB].deg_cd) ? s_cd : '0;
		end
	end
endmodule
`default_nettype wire

// ===== src/segment_intersect_depth.sv =====
// channel   direction  handshake          payload
// input     in         push / full        a_x a_y a_z b_x b_y b_z c_x c_y c_z d_x d_y d_z
// result    out        empty / pop        hit depth_ab depth_cd
// config    in         cfg_we             cfg_index cfg_data
//
// one item per cycle while full is low and the output is popped; latency is 5 front stages, 1 queue slot,
// 2 multiply stages, COORD_WIDTH+1 divider stages and the output register
// the divider pipeline retires one quotient bit per stage for both depths
// reset clears the valid bits and pointers and loads the threshold defaults
// full rises when the mid queue plus items in the front stages reach 8
// the back stalls as a whole only while the output register holds an item and pop is low
`default_nettype none
module segment_intersect_depth #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic signed [COORD_WIDTH-1:0] a_x,
	input  wire logic signed [COORD_WIDTH-1:0] a_y,
	input  wire logic signed [COORD_WIDTH-1:0] a_z,
	input  wire logic signed [COORD_WIDTH-1:0] b_x,
	input  wire logic signed [COORD_WIDTH-1:0] b_y,
	input  wire logic signed [COORD_WIDTH-1:0] b_z,
	input  wire logic signed [COORD_WIDTH-1:0] c_x,
	input  wire logic signed [COORD_WIDTH-1:0] c_y,
	input  wire logic signed [COORD_WIDTH-1:0] c_z,
	input  wire logic signed [COORD_WIDTH-1:0] d_x,
	input  wire logic signed [COORD_WIDTH-1:0] d_y,
	input  wire logic signed [COORD_WIDTH-1:0] d_z,
	output logic                               empty,
	input  wire logic                          pop,
	output logic                               hit,
	output logic signed [COORD_WIDTH-1:0]      depth_ab,
	output logic signed [COORD_WIDTH-1:0]      depth_cd,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [sid_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sid_pkg::*;

	localparam int C      = COORD_WIDTH;
	localparam int M      = 2 * C + 3;
	localparam int ITEM_W = 5 + 3 * M + 2 * C + 2 * (C + 1);

	logic [DET_THR_W-1:0] det_thr_q;
	logic [EXT_THR_W-1:0] ext_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_thr_q <= DET_THR_RST;
			ext_thr_q <= EXT_THR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DET_THR: det_thr_q <= cfg_data[DET_THR_W-1:0];
				REG_EXT_THR: ext_thr_q <= cfg_data[EXT_THR_W-1:0];
				default: ;
			endcase
		end
	end

	logic                accept;
	logic                f_valid;
	logic [ITEM_W-1:0]   f_data;
	logic [FLIGHT_W-1:0] inflight;
	logic [ITEM_W-1:0]   q_data;
	sid_qstat_t          qstat;
	logic                q_pop;
	logic                b_valid;
	logic [CNT_W:0]      credit;

	assign credit = (CNT_W + 1)'(qstat.count) + (CNT_W + 1)'(inflight);
	assign full   = credit >= (CNT_W + 1)'(MID_DEPTH);
	assign accept = push && !full;

	sid_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS),
		.ITEM_W     (ITEM_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.a_x(a_x), .a_y(a_y), .a_z(a_z),
		.b_x(b_x), .b_y(b_y), .b_z(b_z),
		.c_x(c_x), .c_y(c_y), .c_z(c_z),
		.d_x(d_x), .d_y(d_y), .d_z(d_z),
		.det_thr  (det_thr_q),
		.ext_thr  (ext_thr_q),
		.out_valid(f_valid),
		.out_data (f_data),
		.inflight (inflight)
	);

	sid_queue #(
		.WIDTH(ITEM_W)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (f_valid),
		.wdata (f_data),
		.pop   (q_pop),
		.rdata (q_data),
		.stat  (qstat)
	);

	sid_back #(
		.COORD_WIDTH(COORD_WIDTH),
		.ITEM_W     (ITEM_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!qstat.empty),
		.in_data  (q_data),
		.pop      (pop),
		.take     (q_pop),
		.out_valid(b_valid),
		.hit      (hit),
		.depth_ab (depth_ab),
		.depth_cd (depth_cd)
	);

	assign empty = !b_valid;

`include "segment_intersect_depth_assert.svh"

	`SID_ASSERT(a_mid_no_overflow, f_valid && !q_pop |-> qstat.count < CNT_W'(MID_DEPTH), "mid queue overflow")
	`SID_ASSERT(a_credit_bound, credit <= (CNT_W + 1)'(MID_DEPTH), "front credit exceeded")
	`SID_ASSERT(a_miss_zero, !empty && !hit |-> depth_ab == '0 && depth_cd == '0, "miss item with depth")
	`SID_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> empty && !full, "not idle in reset")
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sid_pkg::*;

	typedef logic signed [31:0] coord_t;
	typedef coord_t pair_t [12];
	typedef logic signed [127:0] wide_t;

	typedef struct {
		logic   hit;
		coord_t depth_ab;
		coord_t depth_cd;
	} depth_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_DET_THR;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	coord_t pin [12];
	logic full, empty, hit;
	coord_t depth_ab, depth_cd;

	logic [DET_THR_W-1:0] det_thr = DET_THR_RST;
	logic [EXT_THR_W-1:0] ext_thr = EXT_THR_RST;
	depth_res_t depth_q [$];
	int errors = 0;
	int stall_len = 0;
	bit busy_pop = 1'b0;

	initial for (int i = 0; i < 12; i++) pin[i] = '0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	segment_intersect_depth i_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.a_x(pin[0]), .a_y(pin[1]), .a_z(pin[2]),
		.b_x(pin[3]), .b_y(pin[4]), .b_z(pin[5]),
		.c_x(pin[6]), .c_y(pin[7]), .c_z(pin[8]),
		.d_x(pin[9]), .d_y(pin[10]), .d_z(pin[11]),
		.empty(empty), .pop(pop), .hit(hit), .depth_ab(depth_ab), .depth_cd(depth_cd),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	function automatic wide_t mag(wide_t v);
		return v < 0 ? -v : v;
	endfunction

	function automatic bit in_unit(wide_t num, wide_t den);
		if (num == 0) return 1'b1;
		return ((num < 0) == (den < 0)) && mag(num) <= mag(den);
	endfunction

	function automatic coord_t interp(wide_t num, wide_t den, coord_t z0, wide_t dz);
		wide_t prod, q, v;
		prod = num * dz;
		q = mag(prod) / mag(den);
		v = ((prod < 0) != (den < 0)) ? wide_t'(z0) - q : wide_t'(z0) + q;
		if (v > 128'sd2147483647) v = 128'sd2147483647;
		if (v < -128'sd2147483648) v = -128'sd2147483648;
		return coord_t'(v);
	endfunction

	function automatic depth_res_t predict_depths(pair_t p);
		depth_res_t res;
		wide_t rx, ry, sx, sy, ex, ey, det, tn, un;
		res = '{1'b0, '0, '0};
		rx = wide_t'(p[3]) - wide_t'(p[0]);
		ry = wide_t'(p[4]) - wide_t'(p[1]);
		sx = wide_t'(p[9]) - wide_t'(p[6]);
		sy = wide_t'(p[10]) - wide_t'(p[7]);
		ex = wide_t'(p[6]) - wide_t'(p[0]);
		ey = wide_t'(p[7]) - wide_t'(p[1]);
		det = rx * sy - ry * sx;
		tn = ex * sy - ey * sx;
		un = ex * ry - ey * rx;
		if (det == 0 || mag(det) < wide_t'(det_thr)) return res;
		if (!in_unit(tn, det) || !in_unit(un, det)) return res;
		res.hit = 1'b1;
		if ((mag(rx) > mag(ry) ? mag(rx) : mag(ry)) >= wide_t'(ext_thr))
			res.depth_ab = interp(tn, det, p[2], wide_t'(p[5]) - wide_t'(p[2]));
		if ((mag(sx) > mag(sy) ? mag(sx) : mag(sy)) >= wide_t'(ext_thr))
			res.depth_cd = interp(un, det, p[8], wide_t'(p[11]) - wide_t'(p[8]));
		return res;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_pair(pair_t p);
		int gap;
		for (int i = 0; i < 12; i++) pin[i] <= p[i];
		push <= 1'b1;
		do @(posedge clk); while (full);
		depth_q.push_back(predict_depths(p));
		gap = gap_len();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] val);
		push <= 1'b0;
		@(posedge clk);
		while (depth_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DET_THR) det_thr = val[DET_THR_W-1:0];
		else ext_thr = val[EXT_THR_W-1:0];
	endtask

	function automatic pair_t make_pair(coord_t ax, coord_t ay, coord_t bx, coord_t by,
		coord_t cx, coord_t cy, coord_t dx, coord_t dy);
		pair_t p;
		p = '{ax, ay, coord_t'($urandom), bx, by, coord_t'($urandom),
			cx, cy, coord_t'($urandom), dx, dy, coord_t'($urandom)};
		return p;
	endfunction

	// segments built around a shared point, mostly crossing
	function automatic pair_t crossing_pair();
		pair_t p;
		int px, py, rx, ry, sx, sy, k, m, sc;
		px = $signed($urandom) >>> 11;
		py = $signed($urandom) >>> 11;
		sc = $urandom_range(0, 22);
		rx = $signed($urandom) >>> (31 - sc);
		ry = $signed($urandom) >>> (31 - sc);
		sc = $urandom_range(0, 22);
		sx = $signed($urandom) >>> (31 - sc);
		sy = $signed($urandom) >>> (31 - sc);
		if ($urandom_range(0, 9) == 0) begin
			sx = rx * 2;
			sy = ry * 2;
		end
		k = $urandom_range(0, 3) == 0 ? 256 * $urandom_range(0, 1) : $urandom_range(0, 300);
		m = $urandom_range(0, 3) == 0 ? 256 * $urandom_range(0, 1) : $urandom_range(0, 300);
		p = make_pair(px - rx * k / 256, py - ry * k / 256, 0, 0,
			px - sx * m / 256, py - sy * m / 256, 0, 0);
		p[3] = p[0] + rx;
		p[4] = p[1] + ry;
		p[9] = p[6] + sx;
		p[10] = p[7] + sy;
		return p;
	endfunction

	function automatic pair_t noise_pair();
		pair_t p;
		for (int i = 0; i < 12; i++) p[i] = $urandom;
		return p;
	endfunction

	// result side: random stalls on pop, or pop held high while busy_pop is set
	always @(posedge clk) begin
		if (stall_len > 0) begin
			stall_len <= stall_len - 1;
			pop <= 1'b0;
		end else if (busy_pop) begin
			pop <= 1'b1;
		end else begin
			stall_len <= gap_len();
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin
		depth_res_t want;
		if (arst_n && pop && !empty) begin
			if (depth_q.size() == 0) begin
				$display("%0t: item with nothing expected: hit %0b ab %0d cd %0d",
					$time, hit, depth_ab, depth_cd);
				errors++;
			end else begin
				want = depth_q.pop_front();
				if (hit !== want.hit) begin
					$display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
					errors++;
				end
				if (depth_ab !== want.depth_ab) begin
					$display("%0t: depth_ab expected %0d actual %0d",
						$time, want.depth_ab, depth_ab);
					errors++;
				end
				if (depth_cd !== want.depth_cd) begin
					$display("%0t: depth_cd expected %0d actual %0d",
						$time, want.depth_cd, depth_cd);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		coord_t mx, mn;
		mx = 32'sh7fffffff;
		mn = 32'sh80000000;
		send_pair('{default: mx});
		send_pair('{default: mn});
		send_pair(make_pair(mn, mn, mx, mx, mn, mx, mx, mn));
		send_pair(make_pair(mx, mn, mn, mx, mn, mn, mx, mx));
		send_pair(make_pair(0, 0, 65536, 65536, 0, 65536, 65536, 0));
		// parallel and collinear
		send_pair(make_pair(0, 0, 65536, 0, 0, 65536, 65536, 65536));
		send_pair(make_pair(0, 0, 65536, 0, 131072, 0, 196608, 0));
		// determinant below and above the threshold
		send_pair(make_pair(0, 0, 1, 0, 0, 0, 0, 1));
		send_pair(make_pair(0, 0, 100, 0, 50, -50, 50, 50));
		// touching at the end points
		send_pair(make_pair(0, 0, 65536, 0, 0, 0, 0, 65536));
		send_pair(make_pair(0, 0, 65536, 0, 65536, -65536, 65536, 65536));
		// just outside one segment, then crossing cases
		send_pair(make_pair(0, 0, 65536, 0, 65537, -65536, 65537, 65536));
		send_pair(make_pair(0, 0, 65536, 65536, 0, 65536, 65536, 0));
		for (int i = 0; i < 8; i++) send_pair(crossing_pair());
	endtask

	task automatic test_det_threshold();
		write_reg(REG_DET_THR, '0);
		send_pair(make_pair(0, 0, 1, 0, 0, 0, 0, 1));
		send_pair(make_pair(0, 0, 65536, 0, 0, 65536, 65536, 65536));
		for (int i = 0; i < 20; i++) send_pair(crossing_pair());
		write_reg(REG_DET_THR, 33'h1_0000_0000);
		send_pair(make_pair(0, 0, 65536, 0, 0, -65536, 0, 65536));
		send_pair(make_pair(0, 0, 65536, 0, 0, -32768, 0, 65536));
		for (int i = 0; i < 20; i++) send_pair(crossing_pair());
		write_reg(REG_DET_THR, {1'b0, 32'($urandom)} >> $urandom_range(0, 31));
		for (int i = 0; i < 40; i++) send_pair(crossing_pair());
	endtask

	task automatic test_extent_threshold();
		write_reg(REG_EXT_THR, '0);
		write_reg(REG_DET_THR, '0);
		send_pair(make_pair(0, 0, 1, 0, 0, 0, 0, 1));
		for (int i = 0; i < 20; i++) send_pair(crossing_pair());
		write_reg(REG_EXT_THR, {16'($urandom), 17'h10000});
		send_pair(make_pair(0, 0, 65535, 0, 100, -65536, 100, 65536));
		send_pair(make_pair(0, 0, 65536, 0, 100, -65535, 100, 65536));
		for (int i = 0; i < 30; i++) send_pair(crossing_pair());
		write_reg(REG_EXT_THR, 33'($urandom));
		for (int i = 0; i < 30; i++) send_pair(crossing_pair());
	endtask

	task automatic test_random();
		for (int n = 0; n < 4; n++) begin
			write_reg(REG_DET_THR, $urandom_range(0, 3) == 0 ? 33'(DET_THR_RST)
				: {1'b0, 32'($urandom)} >> $urandom_range(8, 32));
			write_reg(REG_EXT_THR, {16'($urandom), 17'($urandom_range(0, 65536))}
				>> ($urandom_range(0, 1) * 10));
			busy_pop = (n == 2);
			for (int i = 0; i < 420; i++)
				send_pair($urandom_range(0, 4) == 0 ? noise_pair() : crossing_pair());
		end
		busy_pop = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_det_threshold();
		test_extent_threshold();
		test_random();
		push <= 1'b0;
		while (depth_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire
